@@ sv/sra_pkg.sv @@
// Shared types and constants for the spike rejecting sample averager.
// Used by the top level and its checker; depends on nothing else.
package sra_pkg;

	localparam logic [15:0] MAX16 = 16'hFFFF;

	// Register reset values.
	localparam logic        END_MODE_RST  = 1'b0;
	localparam logic [15:0] TARGET_RST    = 16'd100;
	localparam logic [15:0] WINDOW_RST    = 16'd1000;
	localparam logic [15:0] THRESHOLD_RST = 16'd100;

	// Error run handling and the allowed error ratio in count mode.
	localparam logic [3:0] ERR_RUN_LIMIT  = 4'd10;
	localparam logic [3:0] ERR_RUN_RESEED = 4'd5;
	localparam int         ERR_RATIO      = 30;

	// Restoring division: 40 dividend bits, one bit per step.
	localparam int DIV_STEPS = 40;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		CFG_END_MODE  = 2'd0,
		CFG_TARGET    = 2'd1,
		CFG_WINDOW    = 2'd2,
		CFG_THRESHOLD = 2'd3
	} cfg_index_t;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_RESTART = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] sample;
	} sra_in_t;

	typedef struct packed {
		logic signed [23:0] mean_q8;
		logic [1:0]         status;
		logic [15:0]        accepted_count;
	} sra_out_t;

endpackage

@@ sv/spike_rejecting_sample_averager_unit.sv @@
// Top level of the spike rejecting sample averager: sequencer, shared adder and state.
// Depends on sra_pkg for the payload types, register indexes and constants.
//
//  Channel   Direction  Handshake              Payload
//  sample    in         sample_valid/stall     sra_in_t  (op, sample)
//  result    out        result_valid/stall     sra_out_t (mean_q8, status, accepted_count)
//  cfg       in         cfg_valid/cfg_ready    cfg_index (2 bits), cfg_data (16 bits)
//
// A tick goes through S_TICK; a sample through S_DIFF, and unless it seeds the reference
// on through S_MAG, S_CMP and, if accepted, S_ACC and S_END. An item closing a measurement
// with a mean then uses the single 34-bit adder to take the magnitude of the sum, run the
// restoring division one quotient bit per cycle over 40 steps and negate the quotient for a
// negative sum; S_EMIT loads the output register, directly for a restart or empty window.
// Reset is asynchronous and active low; it restores the register defaults and clears the
// measurement. The block stalls the sample channel while an item is in work. A finished
// result sits in an output register, so a new item may be taken while it waits; only the
// next result waits for that register to drain.
module spike_rejecting_sample_averager_unit
	import sra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sra_in_t     sample_item,
	output logic        result_valid,
	input  logic        result_stall,
	output sra_out_t    result_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK,
		S_DIFF,
		S_MAG,
		S_CMP,
		S_ACC,
		S_END,
		S_ABSUM,
		S_DIV,
		S_SIGN,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic        end_mode_q;
	logic [15:0] target_q;
	logic [15:0] window_q;
	logic [15:0] threshold_q;

	// Measurement state.
	logic signed [15:0] ref_q;
	logic               seeded_q;
	logic signed [32:0] sum_q;
	logic [15:0]        accepted_q;
	logic [3:0]         err_run_q;
	logic [15:0]        err_total_q;
	logic [15:0]        elapsed_q;

	// Working registers of the sequencer.
	sra_in_t              item_q;
	logic signed [16:0]   diff_q;
	logic [16:0]          mag_q;
	logic [39:0]          dvd_q;
	logic [16:0]          rem_q;
	logic [23:0]          quo_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [23:0]          mean_q;
	logic [1:0]           status_q;

	sra_out_t result_q;
	logic     result_valid_q;

	// The one adder that every arithmetic step goes through.
	logic [33:0] alu_a;
	logic [33:0] alu_b;
	logic        alu_cin;
	logic [33:0] alu_y;

	logic        sample_take;
	logic        result_take;
	logic        emit_fire;
	logic [16:0] rem_shift;
	logic [15:0] elapsed_next;
	logic [3:0]  err_run_next;
	logic [20:0] err_scaled;

	assign sample_take  = sample_valid && !sample_stall;
	assign result_take  = result_valid_q && !result_stall;
	// A result is loaded once the output register is free or drains at this edge.
	assign emit_fire    = (state_q == S_EMIT) && (!result_valid_q || !result_stall);
	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	assign rem_shift    = {rem_q[15:0], dvd_q[39]};
	assign elapsed_next = (elapsed_q == MAX16) ? elapsed_q : elapsed_q + 16'd1;
	assign err_run_next = err_run_q + 4'd1;
	// The error total passes when it is no more than target / 30, that is 30 * errors <= target.
	assign err_scaled   = 21'(err_total_q) * 21'(ERR_RATIO);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_cin = 1'b0;
		case (state_q)
			S_DIFF: begin
				alu_a   = {{18{item_q.sample[15]}}, item_q.sample};
				alu_b   = ~{{18{ref_q[15]}}, ref_q};
				alu_cin = 1'b1;
			end
			S_MAG: begin
				if (diff_q[16]) begin
					alu_b   = ~{{17{diff_q[16]}}, diff_q};
					alu_cin = 1'b1;
				end else begin
					alu_a = {{17{diff_q[16]}}, diff_q};
				end
			end
			S_CMP: begin
				alu_a   = {17'b0, mag_q};
				alu_b   = ~{18'b0, threshold_q};
				alu_cin = 1'b1;
			end
			S_ACC: begin
				alu_a = {sum_q[32], sum_q};
				alu_b = {{18{item_q.sample[15]}}, item_q.sample};
			end
			S_ABSUM: begin
				if (sum_q[32]) begin
					alu_b   = ~{sum_q[32], sum_q};
					alu_cin = 1'b1;
				end else begin
					alu_a = {sum_q[32], sum_q};
				end
			end
			S_DIV: begin
				alu_a   = {17'b0, rem_shift};
				alu_b   = ~{18'b0, accepted_q};
				alu_cin = 1'b1;
			end
			S_SIGN: begin
				if (neg_q) begin
					alu_b   = ~{10'b0, quo_q};
					alu_cin = 1'b1;
				end else begin
					alu_a = {10'b0, quo_q};
				end
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_cin = 1'b0;
			end
		endcase
	end

	assign alu_y = alu_a + alu_b + {33'b0, alu_cin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			end_mode_q     <= END_MODE_RST;
			target_q       <= TARGET_RST;
			window_q       <= WINDOW_RST;
			threshold_q    <= THRESHOLD_RST;
			ref_q          <= '0;
			seeded_q       <= 1'b0;
			sum_q          <= '0;
			accepted_q     <= '0;
			err_run_q      <= '0;
			err_total_q    <= '0;
			elapsed_q      <= '0;
			item_q         <= '0;
			diff_q         <= '0;
			mag_q          <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			quo_q          <= '0;
			neg_q          <= 1'b0;
			cnt_q          <= '0;
			mean_q         <= '0;
			status_q       <= STATUS_OK;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_END_MODE:  end_mode_q  <= cfg_data[0];
					CFG_TARGET:    target_q    <= cfg_data;
					CFG_WINDOW:    window_q    <= cfg_data;
					CFG_THRESHOLD: threshold_q <= cfg_data;
					default:       ;
				endcase
			end

			if (emit_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_take) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_take) begin
						item_q  <= sample_item;
						state_q <= (sample_item.op == OP_TICK) ? S_TICK : S_DIFF;
					end
				end
				S_TICK: begin
					// Ticks count only in time mode and only once a measurement is seeded.
					if (!end_mode_q || !seeded_q) begin
						state_q <= S_IDLE;
					end else begin
						elapsed_q <= elapsed_next;
						if (elapsed_next >= window_q) begin
							if (accepted_q == '0) begin
								status_q <= STATUS_EMPTY;
								mean_q   <= '0;
								state_q  <= S_EMIT;
							end else begin
								status_q <= STATUS_OK;
								state_q  <= S_ABSUM;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIFF: begin
					if (!seeded_q) begin
						ref_q    <= item_q.sample;
						seeded_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						diff_q  <= alu_y[16:0];
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					mag_q   <= alu_y[16:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					// A negative difference of magnitude and threshold accepts the sample.
					if (alu_y[33]) begin
						ref_q     <= item_q.sample;
						err_run_q <= '0;
						state_q   <= (accepted_q != MAX16) ? S_ACC : S_END;
					end else begin
						if (err_total_q != MAX16) begin
							err_total_q <= err_total_q + 16'd1;
						end
						// A long run of errors means the reference itself has moved.
						if (err_run_next > ERR_RUN_LIMIT) begin
							ref_q     <= item_q.sample;
							err_run_q <= ERR_RUN_RESEED;
						end else begin
							err_run_q <= err_run_next;
						end
						state_q <= S_IDLE;
					end
				end
				S_ACC: begin
					sum_q      <= alu_y[32:0];
					accepted_q <= accepted_q + 16'd1;
					state_q    <= S_END;
				end
				S_END: begin
					if (!end_mode_q && (accepted_q >= target_q)) begin
						if (err_scaled <= {5'b0, target_q}) begin
							status_q <= STATUS_OK;
							state_q  <= S_ABSUM;
						end else begin
							status_q <= STATUS_RESTART;
							mean_q   <= '0;
							state_q  <= S_EMIT;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ABSUM: begin
					// The dividend is the magnitude of the sum scaled by 256.
					dvd_q   <= {alu_y[31:0], 8'b0};
					neg_q   <= sum_q[32];
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!alu_y[33]) begin
						rem_q <= alu_y[16:0];
						quo_q <= {quo_q[22:0], 1'b1};
					end else begin
						rem_q <= rem_shift;
						quo_q <= {quo_q[22:0], 1'b0};
					end
					dvd_q <= {dvd_q[38:0], 1'b0};
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					mean_q  <= alu_y[23:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Wait until the output register is free, then close the measurement.
					if (emit_fire) begin
						result_q.mean_q8        <= mean_q;
						result_q.status         <= status_q;
						result_q.accepted_count <= accepted_q;
						ref_q                   <= '0;
						seeded_q                <= 1'b0;
						sum_q                   <= '0;
						accepted_q              <= '0;
						err_run_q               <= '0;
						err_total_q             <= '0;
						elapsed_q               <= '0;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/sra_checker.sv @@
// Port-level checker for the spike rejecting sample averager, bound to the top level.
// Depends on sra_pkg for the payload types and status codes.
module sra_checker
	import sra_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input sra_out_t    result_item
);

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed or was dropped");

	// Every accepted item keeps the block busy for at least the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample channel open right after a transaction");

	// An empty time window reports no samples and no mean.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status == STATUS_EMPTY |->
			result_item.accepted_count == '0 && result_item.mean_q8 == '0)
		else $error("empty result with samples or mean");

	// A restarted measurement carries no mean.
	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status == STATUS_RESTART |-> result_item.mean_q8 == '0)
		else $error("restart result with a mean");

	// A good result always rests on at least one accepted sample.
	a_ok_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status == STATUS_OK |-> result_item.accepted_count != '0)
		else $error("good result without accepted samples");

endmodule

bind spike_rejecting_sample_averager_unit sra_checker u_sra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for spike_rejecting_sample_averager_unit: a predictor of the
// averaging and spike rejection rules, a randomized sample/tick driver and a result monitor.
// Depends only on sra_pkg and the top level of the averager.
module tb;
	import sra_pkg::*;

	// Rule constants of the averager, kept apart from the design's own copies.
	localparam logic [15:0] SAT16        = 16'hFFFF;
	localparam logic [3:0]  RESEED_AFTER = 4'd10;
	localparam logic [3:0]  RUN_RESEEDED = 4'd5;
	localparam int          ERR_DIVISOR  = 30;
	// Quiet cycles before a register write: one closing division plus a margin.
	localparam int          SETTLE_CYCLES = 60;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	sra_in_t     sample_item  = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	sra_out_t    result_item;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = CFG_END_MODE;
	logic [15:0] cfg_data     = '0;

	spike_rejecting_sample_averager_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Samples and ticks waiting to be sent, and the measurement reports the predictor
	// expects, oldest first.
	sra_in_t  adc_events[$];
	sra_out_t expected_reports[$];

	int mismatches = 0;
	int send_gap   = 0;
	int stall_left = 0;
	bit quiet      = 1'b0;
	int walk_val   = 0;

	// Predictor copy of the registers.
	logic        mode_cfg;
	logic [15:0] target_cfg;
	logic [15:0] window_cfg;
	logic [15:0] thr_cfg;

	// Predictor copy of the measurement state.
	logic signed [15:0] ref_smp;
	logic               is_seeded;
	logic signed [32:0] acc_sum;
	logic [15:0]        acc_cnt;
	logic [3:0]         err_run;
	logic [15:0]        err_cnt;
	logic [15:0]        ms_cnt;

	function automatic void clear_measurement();
		ref_smp   = '0;
		is_seeded = 1'b0;
		acc_sum   = '0;
		acc_cnt   = '0;
		err_run   = '0;
		err_cnt   = '0;
		ms_cnt    = '0;
	endfunction

	// Every report closes the measurement, so the next sample seeds a fresh one.
	// The mean is the Q8 quotient truncated toward zero; a restart reports no mean.
	function automatic void close_measurement(logic [1:0] st);
		sra_out_t rpt;
		longint   q;
		q = 0;
		if (st != STATUS_RESTART && acc_cnt != 0)
			q = (longint'(acc_sum) * 256) / longint'(acc_cnt);
		rpt.mean_q8        = q[23:0];
		rpt.status         = st;
		rpt.accepted_count = acc_cnt;
		expected_reports.push_back(rpt);
		clear_measurement();
	endfunction

	// Advances the predicted state by one accepted transaction on the sample channel.
	function automatic void predict_averager(sra_in_t it);
		int   d;
		logic hit;
		if (it.op == OP_TICK) begin
			// Ticks only count in time mode, and only once a measurement is seeded.
			if (mode_cfg && is_seeded) begin
				if (ms_cnt != SAT16)
					ms_cnt++;
				if (ms_cnt >= window_cfg)
					close_measurement((acc_cnt == 0) ? STATUS_EMPTY : STATUS_OK);
			end
			return;
		end
		if (!is_seeded) begin
			ref_smp   = it.sample;
			is_seeded = 1'b1;
			return;
		end
		d = int'(it.sample) - int'(ref_smp);
		if (d < 0)
			d = -d;
		hit = (d < int'(thr_cfg));
		if (hit) begin
			ref_smp = it.sample;
			err_run = '0;
			// A saturated count still moves the reference but sums nothing more.
			if (acc_cnt != SAT16) begin
				acc_sum += it.sample;
				acc_cnt++;
			end
		end else begin
			err_run++;
			if (err_cnt != SAT16)
				err_cnt++;
			// A long run of rejections means the signal really moved: follow it.
			if (err_run > RESEED_AFTER) begin
				ref_smp = it.sample;
				err_run = RUN_RESEEDED;
			end
		end
		if (!mode_cfg && hit && acc_cnt >= target_cfg)
			close_measurement((err_cnt <= target_cfg / ERR_DIVISOR) ? STATUS_OK : STATUS_RESTART);
	endfunction

	function automatic void push_sample(int v);
		sra_in_t it;
		it.op     = OP_SAMPLE;
		it.sample = 16'(v);
		adc_events.push_back(it);
	endfunction

	function automatic void push_tick();
		sra_in_t it;
		it.op     = OP_TICK;
		it.sample = 16'($urandom);
		adc_events.push_back(it);
	endfunction

	// Queues a slowly wandering signal whose steps stay under the current threshold, with
	// ticks mixed in, isolated spikes, and now and then a burst long enough to force a reseed.
	function automatic void add_walk(int n, int tick_pct, int spike_pct);
		int lim;
		int k;
		int burst;
		int spike;
		lim = int'(thr_cfg) - 1;
		if (lim < 0)
			lim = 0;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 99) < tick_pct) begin
				push_tick();
				k++;
			end else if ($urandom_range(0, 99) < spike_pct) begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 13) : 1;
				spike = 0;
				repeat (burst) begin
					spike = int'($urandom_range(0, 65535)) - 32768;
					push_sample(spike);
				end
				if (burst > 1)
					walk_val = spike;
				k += burst;
			end else begin
				walk_val += int'($urandom_range(0, 2 * lim)) - lim;
				if (walk_val > 32767)
					walk_val = 32767;
				if (walk_val < -32768)
					walk_val = -32768;
				push_sample(walk_val);
				k++;
			end
		end
	endfunction

	// One transaction on the register channel; the predictor takes the value at the
	// same edge as the block.
	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_END_MODE:  mode_cfg   = val[0];
			CFG_TARGET:    target_cfg = val;
			CFG_WINDOW:    window_cfg = val;
			CFG_THRESHOLD: thr_cfg    = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic m, logic [15:0] tg, logic [15:0] w, logic [15:0] th);
		write_reg(CFG_END_MODE, {15'd0, m});
		write_reg(CFG_TARGET, tg);
		write_reg(CFG_WINDOW, w);
		write_reg(CFG_THRESHOLD, th);
	endtask

	// Waits until everything queued has gone in and every expected report has come out,
	// then lets the block finish any item that closes nothing. State is read at the
	// falling edge, where the driver and the monitor have both settled.
	task automatic settle();
		do
			@(negedge clk);
		while (adc_events.size() != 0 || sample_valid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: a transaction completes when valid is high and stall is low at the edge.
	// The payload is held while stalled; a new one is offered only after a completed
	// transaction or while valid is low. Gaps come in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				predict_averager(sample_item);
			if (!sample_valid || !sample_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 7);
					sample_valid <= 1'b0;
				end else if (adc_events.size() != 0) begin
					sample_valid <= 1'b1;
					sample_item  <= adc_events.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every completed result transaction is matched against the oldest
	// expected report, field by field. Backpressure comes in bursts like the gaps.
	always @(posedge clk) begin : result_check
		sra_out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result mean_q8=%0d status=%0d accepted_count=%0d",
							$time, result_item.mean_q8, result_item.status,
							result_item.accepted_count);
				end else begin
					want = expected_reports.pop_front();
					if (result_item.mean_q8 !== want.mean_q8 || result_item.status !== want.status
							|| result_item.accepted_count !== want.accepted_count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch, expected mean_q8=%0d status=%0d %s%0d",
								$time, want.mean_q8, want.status, "accepted_count=",
								want.accepted_count);
							$display("    got mean_q8=%0d status=%0d accepted_count=%0d",
								result_item.mean_q8, result_item.status,
								result_item.accepted_count);
						end
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] th;
		logic        m;
		mode_cfg   = 1'b0;
		target_cfg = 16'd100;
		window_cfg = 16'd1000;
		thr_cfg    = 16'd100;
		clear_measurement();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Count mode at the rails. The first measurement takes one error, which is too
		// many for a target of two, so it restarts; the second is clean at the negative
		// rail. Steps of 99 pass and a step of exactly the threshold does not.
		settle();
		set_config(1'b0, 16'd2, 16'd2, 16'd100);
		push_sample(32767);
		push_sample(32668);
		push_sample(32568);
		push_tick();
		push_sample(32767);
		push_sample(-32768);
		push_sample(-32670);
		push_sample(-32768);

		// Time mode: a tick before seeding is ignored, a window with nothing accepted
		// reports empty, and a window with one negative sample reports its mean.
		settle();
		set_config(1'b1, 16'd2, 16'd2, 16'd100);
		push_tick();
		push_sample(0);
		push_tick();
		push_tick();
		push_sample(5);
		push_sample(-7);
		push_tick();
		push_tick();

		// Eleven rejections in a row reseed the reference onto the new level, which is
		// then accepted.
		settle();
		set_config(1'b0, 16'd1, 16'd2, 16'd1);
		push_sample(0);
		repeat (11) push_sample(1000);
		push_sample(1000);

		// Random part, starting with settings at the extremes. A zero target or window
		// ends at the first accepted sample or the first tick after seeding.
		settle();
		set_config(1'b0, 16'd10, 16'd1000, 16'd100);
		add_walk(120, 5, 5);
		settle();
		set_config(1'b0, 16'd0, 16'd1, 16'hFFFF);
		add_walk(40, 5, 5);
		settle();
		set_config(1'b1, 16'd7, 16'd1, 16'd1);
		add_walk(60, 30, 5);
		settle();
		set_config(1'b1, 16'd7, 16'd0, 16'd300);
		add_walk(60, 30, 5);

		// A measurement left running under a huge target is closed by the next accepted sample
		// once the target is no longer above its count; the same for a long window.
		settle();
		set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'd200);
		add_walk(40, 10, 5);
		settle();
		set_config(1'b0, 16'd5, 16'hFFFF, 16'd200);
		add_walk(80, 10, 5);
		settle();
		set_config(1'b1, 16'd5, 16'hFFFF, 16'd500);
		add_walk(30, 30, 5);
		settle();
		set_config(1'b1, 16'd5, 16'd3, 16'd500);
		add_walk(60, 30, 5);

		repeat (5) begin
			settle();
			m = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: th = 16'd1;
				1: th = 16'($urandom_range(2, 200));
				2: th = 16'($urandom_range(200, 5000));
				default: th = 16'hFFFF;
			endcase
			set_config(m, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)), th);
			add_walk(80, m ? 30 : 5, $urandom_range(0, 15));
		end

		// From here on neither side idles.
		settle();
		quiet = 1'b1;
		set_config(1'b0, 16'd20, 16'd10, 16'd100);
		add_walk(60, 10, 5);

		settle();
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Several times the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
